// ===== hw/rtl/tensor_axis_sum_reducer_unit_assert.svh =====
// assertion macros shared by the reducer checker
`ifndef TENSOR_AXIS_SUM_REDUCER_UNIT_ASSERT_SVH
`define TENSOR_AXIS_SUM_REDUCER_UNIT_ASSERT_SVH

// plain concurrent property on the rising clock, off while reset is low
`define TASR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a signal holds its value over a cycle in which the word is stalled
`define TASR_ASSERT_HOLD(label, clk, rst_n, vld, stl, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && (stl)) |=> $stable(sig)) else $error(msg);

`endif

// ===== hw/rtl/tasr_pkg.sv =====
// types and constants of the tensor axis sum reducer
`default_nettype none

package tasr_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned SumW     = 48;
  localparam int unsigned IndexW   = 12;
  localparam int unsigned RankW    = 2;
  localparam int unsigned AxisW    = 3;
  localparam int unsigned DimW     = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANK       = 3'd0,
    CFG_AXIS       = 3'd1,
    CFG_DIM_FIRST  = 3'd2,
    CFG_DIM_SECOND = 3'd3,
    CFG_DIM_THIRD  = 3'd4
  } cfg_reg_e;

  // reduced axis after normalization
  typedef enum logic [1:0] {
    AX_FIRST  = 2'd0,
    AX_SECOND = 2'd1,
    AX_THIRD  = 2'd2
  } axis_sel_e;

  // per element flags handed from the position walker to the datapath
  typedef struct packed {
    logic first;
    logic done;
    logic last;
  } elem_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tensor_axis_sum_reducer_unit.sv =====
// top level of the tensor axis sum reducer
// usage:
//   input channel carries one Q16.16 tensor element per word (value_i) in
//   row-major order, handshake in_valid_i / in_stall_o
//   output channel carries one completed Q32.16 sum per word with its flat
//   index in the reduced tensor and a last flag on the tensor's final
//   element, handshake out_valid_o / out_stall_i
//   config port writes rank, axis and the three extents by index; every
//   write to a known index restarts the tensor at position zero
// sums: the element that completes a sum passes the modify stage, and the sum
//   is then registered on the output; elements that complete no sum give no word
// throughput: one element per cycle while in_stall_o is low, set by the
//   single read-modify-write of the accumulator memory (read at accept,
//   add and write back in the modify stage, back-to-back hits on one entry are forwarded)
// reset: positions return to zero, rank 2, axis 0, extents 1; the
//   accumulator memory is not cleared, the first element of each entry
//   overwrites it
// stall: while out_stall_i holds a waiting sum, elements that do not
//   complete a sum keep flowing; the input stalls only when the element
//   in flight would produce a second waiting sum
`default_nettype none

module tensor_axis_sum_reducer_unit #(
  parameter int unsigned MAX_DIM = 1024,
  parameter int unsigned MAX_OUT = 4096   // power of two
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tasr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [tasr_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [tasr_pkg::ValueW-1:0]   value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tasr_pkg::SumW-1:0]     sum_o,
  output logic [tasr_pkg::IndexW-1:0]          out_index_o,
  output logic                                 last_o
);
  import tasr_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_OUT);

  // element walker: position counters and accumulator address
  logic              accept;
  logic [AddrW-1:0]  wk_addr;
  elem_info_t        wk_info;

  tasr_walker #(
    .MAX_DIM (MAX_DIM),
    .MAX_OUT (MAX_OUT)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (accept),
    .addr_o      (wk_addr),
    .info_o      (wk_info)
  );

  // accumulator memory, registered read
  logic [SumW-1:0]   acc_mem_q [MAX_OUT];
  logic [SumW-1:0]   rdata_q;

  // modify stage
  logic              s1_valid_q, s1_valid_d;
  logic [ValueW-1:0] s1_value_q;
  logic [AddrW-1:0]  s1_addr_q;
  elem_info_t        s1_info_q;
  logic              fwd_q, fwd_d;
  logic [SumW-1:0]   fwd_sum_q;
  logic              s1_adv;
  logic [SumW-1:0]   acc_old, value_ext, new_sum;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [SumW-1:0]   out_sum_q;
  logic [AddrW-1:0]  out_addr_q;
  logic              out_last_q;

  always_comb begin
    // a completing element waits only if the output word is held
    s1_adv     = s1_valid_q && (!s1_info_q.done || !out_valid_q || !out_stall_i);
    in_stall_o = s1_valid_q && !s1_adv;
    accept     = in_valid_i && !in_stall_o;

    // the entry written on this edge is missed by the read issued on it
    acc_old   = fwd_q ? fwd_sum_q : rdata_q;
    value_ext = {{(SumW-ValueW){s1_value_q[ValueW-1]}}, s1_value_q};
    new_sum   = s1_info_q.first ? value_ext : acc_old + value_ext;

    fwd_d = s1_adv && (s1_addr_q == wk_addr);

    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (s1_adv && s1_info_q.done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= acc_mem_q[wk_addr];
    end
    if (s1_adv) begin
      acc_mem_q[s1_addr_q] <= new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_value_q <= value_i;
      s1_addr_q  <= wk_addr;
      s1_info_q  <= wk_info;
      fwd_sum_q  <= new_sum;
    end
    if (s1_adv && s1_info_q.done) begin
      out_sum_q  <= new_sum;
      out_addr_q <= s1_addr_q;
      out_last_q <= s1_info_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_o       = out_sum_q;
  assign out_index_o = IndexW'(out_addr_q);
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tasr_walker.sv =====
// config registers, row-major position counters and accumulator address
`default_nettype none

module tasr_walker #(
  parameter int unsigned MAX_DIM = 1024,
  parameter int unsigned MAX_OUT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tasr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tasr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          step_i,
  output logic [$clog2(MAX_OUT)-1:0]    addr_o,
  output tasr_pkg::elem_info_t          info_o
);
  import tasr_pkg::*;

  localparam int unsigned DimCap = (MAX_DIM < 2047) ? MAX_DIM : 2047;
  localparam int unsigned PosW   = $clog2(DimCap);
  localparam int unsigned AddrW  = $clog2(MAX_OUT);
  localparam int unsigned ProdW  = PosW + DimW;
  localparam int unsigned IdxW   = (ProdW + 1 > AddrW) ? ProdW + 1 : AddrW;

  logic [RankW-1:0]        rank_q;
  logic signed [AxisW-1:0] axis_q;
  logic [DimW-1:0]         dim0_q, dim1_q, dim2_q;
  logic [PosW-1:0]         p0_q, p1_q, p2_q;
  logic [PosW-1:0]         p0_d, p1_d, p2_d;

  logic                    r3;
  logic [DimW-1:0]         d0, d1, d2;
  logic signed [AxisW:0]   ax_adj, rank_s;
  axis_sel_e               sel;
  logic [DimW-1:0]         e0, e1, e2, pa, da;
  logic [PosW-1:0]         mul_a, add_b;
  logic [DimW-1:0]         mul_b;
  logic [ProdW-1:0]        prod;
  logic [IdxW-1:0]         idx;
  logic [DimW:0]           inc0, inc1, inc2;
  logic                    wrap0, wrap1, wrap2;
  logic                    cfg_hit;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
    if (d == '0) return DimW'(1);
    if (d > DimW'(DimCap)) return DimW'(DimCap);
    return d;
  endfunction

  always_comb begin
    r3     = (rank_q == 2'd3);
    d0     = clamp_dim(dim0_q);
    d1     = clamp_dim(dim1_q);
    d2     = r3 ? clamp_dim(dim2_q) : DimW'(1);
    rank_s = r3 ? 4'sd3 : 4'sd2;
    ax_adj = {axis_q[AxisW-1], axis_q} + (axis_q[AxisW-1] ? rank_s : 4'sd0);
    if (ax_adj < 4'sd0 || ax_adj >= rank_s) begin
      sel = r3 ? AX_THIRD : AX_SECOND;
    end else begin
      sel = axis_sel_e'(ax_adj[1:0]);
    end

    e0 = DimW'(p0_q);
    e1 = DimW'(p1_q);
    e2 = DimW'(p2_q);

    // rank two runs as rank three with a unit last dimension
    case (sel)
      AX_SECOND: begin
        pa = e1; da = d1; mul_a = p0_q; mul_b = d2; add_b = p2_q;
      end
      AX_THIRD: begin
        pa = e2; da = d2; mul_a = p0_q; mul_b = d1; add_b = p1_q;
      end
      default: begin
        pa = e0; da = d0; mul_a = p1_q; mul_b = d2; add_b = p2_q;
      end
    endcase

    prod   = ProdW'(mul_a) * ProdW'(mul_b);
    idx    = IdxW'(prod) + IdxW'(add_b);
    addr_o = idx[AddrW-1:0];

    info_o.first = (pa == '0);
    info_o.done  = (pa == da - DimW'(1));
    info_o.last  = (e0 == d0 - DimW'(1)) && (e1 == d1 - DimW'(1)) &&
                   (e2 == d2 - DimW'(1));

    inc0  = {1'b0, e0} + (DimW+1)'(1);
    inc1  = {1'b0, e1} + (DimW+1)'(1);
    inc2  = {1'b0, e2} + (DimW+1)'(1);
    wrap0 = !(inc0 < {1'b0, d0});
    wrap1 = !(inc1 < {1'b0, d1});
    wrap2 = !(inc2 < {1'b0, d2});

    p0_d = p0_q;
    p1_d = p1_q;
    p2_d = p2_q;
    if (step_i) begin
      if (!wrap2) begin
        p2_d = p2_q + PosW'(1);
      end else begin
        p2_d = '0;
        if (!wrap1) begin
          p1_d = p1_q + PosW'(1);
        end else begin
          p1_d = '0;
          p0_d = wrap0 ? '0 : p0_q + PosW'(1);
        end
      end
    end

    case (cfg_reg_e'(cfg_index_i))
      CFG_RANK, CFG_AXIS, CFG_DIM_FIRST, CFG_DIM_SECOND, CFG_DIM_THIRD: begin
        cfg_hit = cfg_we_i;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RankW'(2);
      axis_q <= '0;
      dim0_q <= DimW'(1);
      dim1_q <= DimW'(1);
      dim2_q <= DimW'(1);
      p0_q   <= '0;
      p1_q   <= '0;
      p2_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_RANK:       rank_q <= cfg_data_i[RankW-1:0];
          CFG_AXIS:       axis_q <= cfg_data_i[AxisW-1:0];
          CFG_DIM_FIRST:  dim0_q <= cfg_data_i[DimW-1:0];
          CFG_DIM_SECOND: dim1_q <= cfg_data_i[DimW-1:0];
          CFG_DIM_THIRD:  dim2_q <= cfg_data_i[DimW-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        p0_q <= '0;
        p1_q <= '0;
        p2_q <= '0;
      end else begin
        p0_q <= p0_d;
        p1_q <= p1_d;
        p2_q <= p2_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tasr_checker.sv =====
// port level checker for the reducer and its bind
`default_nettype none

`include "tensor_axis_sum_reducer_unit_assert.svh"

module tasr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tasr_pkg::SumW-1:0]     sum_o,
  input logic [tasr_pkg::IndexW-1:0]   out_index_o,
  input logic                          last_o
);
  import tasr_pkg::*;

  logic [SumW+IndexW:0] out_word;

  assign out_word = {sum_o, out_index_o, last_o};

  `TASR_ASSERT(a_out_valid_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o, "output word dropped while stalled")
  `TASR_ASSERT_HOLD(a_out_word_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_word, "output word changed while stalled")
  `TASR_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without output backpressure")
  `TASR_ASSERT(a_out_latency, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2), "output word without an element two cycles before")

endmodule

bind tensor_axis_sum_reducer_unit tasr_checker u_tasr_checker (.*);

`default_nettype wire
